>>> sv/camera_point_projection_defines.svh
// Assertion helpers for the camera point projection block.
`ifndef CAMERA_POINT_PROJECTION_DEFINES_SVH
`define CAMERA_POINT_PROJECTION_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CPP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define CPP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/cpp_pkg.sv
`default_nettype none

package cpp_pkg;

  localparam int unsigned TrigW   = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned SizeW   = 12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COLS  = 8'd0,
    REG_ROWS  = 8'd1,
    REG_CAM_X = 8'd2,
    REG_CAM_Y = 8'd3,
    REG_CAM_Z = 8'd4,
    REG_FOCAL = 8'd5,
    REG_YAW   = 8'd6,
    REG_PITCH = 8'd7
  } cfg_reg_e;

  localparam logic [SizeW-1:0]   ColsRst  = 12'd80;
  localparam logic [SizeW-1:0]   RowsRst  = 12'd25;
  localparam logic [7:0]         CamXRst  = 8'd40;
  localparam logic [7:0]         CamYRst  = 8'd12;
  localparam logic [7:0]         CamZRst  = 8'd0;
  localparam logic [SizeW-1:0]   FocalRst = 12'd20;
  localparam logic [CfgDatW-1:0] TrigRst  = 32'h4000_0000;

  localparam int unsigned FlagBehind   = 0;
  localparam int unsigned FlagOnScreen = 1;

endpackage

`default_nettype wire

>>> sv/camera_point_projection.sv
// Channel     | Direction | Contents
// s_axis      | in        | tdata: point_x, point_y, point_z
// m_axis      | out       | tdata: screen_x, screen_y, depth; tuser: behind, on_screen
// cfg         | in        | cfg_index_i selects register, cfg_data_i value, always ready
//
// One item per cycle sustained while the output is not stalled.
// The quotient is built one bit per stage in a COORD_BITS-stage restoring divider.
// rst_ni clears stage valids, the output and skid slots, and the registers.
// A two-slot output (register plus skid) keeps s_axis_tready registered; a stalled
// output freezes the whole pipe once the skid slot is taken.
`default_nettype none

module camera_point_projection #(
  parameter int unsigned COORD_BITS     = 16,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // point_x, point_y, point_z
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // screen_x, screen_y, depth
  output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // behind, on_screen
  output logic [1:0]                             m_axis_tuser,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [cpp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [cpp_pkg::CfgDatW-1:0]       cfg_data_i
);

`include "camera_point_projection_defines.svh"

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned F    = TRIG_FRAC_BITS;
  localparam int unsigned TW   = cpp_pkg::TrigW;
  localparam int unsigned DW   = CB + 1;
  localparam int unsigned P1W  = DW + TW;
  localparam int unsigned R1W  = P1W + 1;
  localparam int unsigned DYW  = DW + F;
  localparam int unsigned R2W  = ((DYW > R1W) ? DYW : R1W) + TW + 1;
  localparam int unsigned SW   = ((CB > 13) ? CB : 13) + 1;
  localparam int unsigned RXW  = R1W + F;
  localparam int unsigned NW   = ((RXW > R2W) ? RXW : R2W) + SW + 1;
  localparam int unsigned IOW  = ((3*CB+7)/8)*8;
  localparam int unsigned CmpW = CB + cpp_pkg::SizeW;

  // ---------------- configuration ----------------
  logic [cpp_pkg::SizeW-1:0]   cols_q, rows_q, focal_q;
  logic signed [CB-1:0]        cam_x_q, cam_y_q, cam_z_q;
  logic [cpp_pkg::CfgDatW-1:0] yaw_q, pitch_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= cpp_pkg::ColsRst;
      rows_q  <= cpp_pkg::RowsRst;
      cam_x_q <= CB'(cpp_pkg::CamXRst);
      cam_y_q <= CB'(cpp_pkg::CamYRst);
      cam_z_q <= CB'(cpp_pkg::CamZRst);
      focal_q <= cpp_pkg::FocalRst;
      yaw_q   <= cpp_pkg::TrigRst;
      pitch_q <= cpp_pkg::TrigRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cpp_pkg::REG_COLS:  cols_q  <= cfg_data_i[cpp_pkg::SizeW-1:0];
        cpp_pkg::REG_ROWS:  rows_q  <= cfg_data_i[cpp_pkg::SizeW-1:0];
        cpp_pkg::REG_CAM_X: cam_x_q <= cfg_data_i[CB-1:0];
        cpp_pkg::REG_CAM_Y: cam_y_q <= cfg_data_i[CB-1:0];
        cpp_pkg::REG_CAM_Z: cam_z_q <= cfg_data_i[CB-1:0];
        cpp_pkg::REG_FOCAL: focal_q <= cfg_data_i[cpp_pkg::SizeW-1:0];
        cpp_pkg::REG_YAW:   yaw_q   <= cfg_data_i;
        cpp_pkg::REG_PITCH: pitch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [TW-1:0] ycos, ysin, pcos, psin;
  logic signed [SW-1:0] scale;
  assign ycos  = $signed(yaw_q[31:16]);
  assign ysin  = $signed(yaw_q[15:0]);
  assign pcos  = $signed(pitch_q[31:16]);
  assign psin  = $signed(pitch_q[15:0]);
  assign scale = SW'(cam_z_q) - SW'({1'b0, focal_q});

  // ---------------- pipeline control ----------------
  logic en;
  logic [8:1] v_q;
  logic [CB:0] dvv_q;
  logic skid_v_q, out_v_q;
  logic push;

  assign en            = !skid_v_q;
  assign s_axis_tready = !skid_v_q;
  assign push          = en && dvv_q[CB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      dvv_q <= '0;
    end else if (en) begin
      v_q   <= {v_q[7:1], s_axis_tvalid};
      dvv_q <= {dvv_q[CB-1:0], v_q[8]};
    end
  end

  // ---------------- stage 1: camera offset ----------------
  logic signed [CB-1:0] px, py, pz;
  assign px = s_axis_tdata[CB-1:0];
  assign py = s_axis_tdata[2*CB-1:CB];
  assign pz = s_axis_tdata[3*CB-1:2*CB];

  logic signed [DW-1:0] dx1_q, dy1_q, dz1_q;
  logic plane1_q;
  logic [CB-1:0] z1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q    <= DW'(px) - DW'(cam_x_q);
      dy1_q    <= DW'(py) - DW'(cam_y_q);
      dz1_q    <= DW'(pz) - DW'(cam_z_q);
      plane1_q <= (pz == cam_z_q);
      z1_q     <= pz;
    end
  end

  // ---------------- stage 2: yaw products ----------------
  logic signed [P1W-1:0] pxc2_q, pzs2_q, pzc2_q, pxs2_q;
  logic signed [DW-1:0]  dy2_q;
  logic plane2_q;
  logic [CB-1:0] z2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxc2_q   <= dx1_q * ycos;
      pzs2_q   <= dz1_q * ysin;
      pzc2_q   <= dz1_q * ycos;
      pxs2_q   <= dx1_q * ysin;
      dy2_q    <= dy1_q;
      plane2_q <= plane1_q;
      z2_q     <= z1_q;
    end
  end

  // ---------------- stage 3: yaw sums ----------------
  logic signed [R1W-1:0] rx3_q, rz3_q;
  logic signed [DW-1:0]  dy3_q;
  logic plane3_q;
  logic [CB-1:0] z3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx3_q    <= R1W'(pxc2_q) + R1W'(pzs2_q);
      rz3_q    <= R1W'(pzc2_q) - R1W'(pxs2_q);
      dy3_q    <= dy2_q;
      plane3_q <= plane2_q;
      z3_q     <= z2_q;
    end
  end

  // ---------------- stage 4: pitch products ----------------
  logic signed [DYW-1:0] dys;
  assign dys = $signed({dy3_q, {F{1'b0}}});

  logic signed [R2W-2:0] pa4_q, pb4_q, pc4_q, pd4_q;
  logic signed [R1W-1:0] rx4_q;
  logic plane4_q;
  logic [CB-1:0] z4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa4_q    <= dys * pcos;
      pb4_q    <= rz3_q * psin;
      pc4_q    <= dys * psin;
      pd4_q    <= rz3_q * pcos;
      rx4_q    <= rx3_q;
      plane4_q <= plane3_q;
      z4_q     <= z3_q;
    end
  end

  // ---------------- stage 5: pitch sums ----------------
  logic signed [R2W-1:0] ry5_q, rz5_q;
  logic signed [R1W-1:0] rx5_q;
  logic plane5_q;
  logic [CB-1:0] z5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ry5_q    <= R2W'(pa4_q) - R2W'(pb4_q);
      rz5_q    <= R2W'(pc4_q) + R2W'(pd4_q);
      rx5_q    <= rx4_q;
      plane5_q <= plane4_q;
      z5_q     <= z4_q;
    end
  end

  // ---------------- stage 6: numerator products ----------------
  logic signed [RXW-1:0] rxs;
  assign rxs = $signed({rx5_q, {F{1'b0}}});

  logic signed [NW-2:0]  m1_q, m2_q, m3_q, m4_q;
  logic signed [R2W-1:0] rz6_q;
  logic behind6_q;
  logic [CB-1:0] z6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q      <= rxs * scale;
      m2_q      <= rz5_q * cam_x_q;
      m3_q      <= ry5_q * scale;
      m4_q      <= rz5_q * cam_y_q;
      rz6_q     <= rz5_q;
      behind6_q <= plane5_q || !rz5_q[R2W-1];
      z6_q      <= z5_q;
    end
  end

  // ---------------- stage 7: numerator sums ----------------
  logic signed [NW-1:0]  nx7_q, ny7_q;
  logic signed [R2W-1:0] rz7_q;
  logic behind7_q;
  logic [CB-1:0] z7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx7_q     <= NW'(m1_q) + NW'(m2_q);
      ny7_q     <= NW'(m3_q) + NW'(m4_q);
      rz7_q     <= rz6_q;
      behind7_q <= behind6_q;
      z7_q      <= z6_q;
    end
  end

  // ---------------- stage 8: magnitudes ----------------
  logic [NW-1:0]  ax8_q, ay8_q;
  logic [R2W-1:0] ad8_q;
  logic negx8_q, negy8_q, behind8_q;
  logic [CB-1:0] z8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax8_q     <= nx7_q[NW-1] ? NW'(-nx7_q) : NW'(nx7_q);
      ay8_q     <= ny7_q[NW-1] ? NW'(-ny7_q) : NW'(ny7_q);
      ad8_q     <= rz7_q[R2W-1] ? R2W'(-rz7_q) : R2W'(rz7_q);
      negx8_q   <= nx7_q[NW-1] ^ rz7_q[R2W-1];
      negy8_q   <= ny7_q[NW-1] ^ rz7_q[R2W-1];
      behind8_q <= behind7_q;
      z8_q      <= z7_q;
    end
  end

  // ---------------- stage 9: overflow test, then one quotient bit per stage ----------------
  typedef struct packed {
    logic          behind;
    logic          negx;
    logic          negy;
    logic          ovx;
    logic          ovy;
    logic [CB-1:0] z;
  } dctl_t;

  logic [NW-1:0] rx_q [CB+1];
  logic [NW-1:0] ry_q [CB+1];
  logic [NW-1:0] dv_q [CB+1];
  logic [CB-1:0] qx_q [CB+1];
  logic [CB-1:0] qy_q [CB+1];
  dctl_t         dc_q [CB+1];

  logic [NW-1:0] dlim;
  assign dlim = NW'(ad8_q) << CB;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q[0]        <= ax8_q;
      ry_q[0]        <= ay8_q;
      dv_q[0]        <= NW'(ad8_q);
      qx_q[0]        <= '0;
      qy_q[0]        <= '0;
      dc_q[0].behind <= behind8_q;
      dc_q[0].negx   <= negx8_q;
      dc_q[0].negy   <= negy8_q;
      dc_q[0].ovx    <= (ax8_q >= dlim);
      dc_q[0].ovy    <= (ay8_q >= dlim);
      dc_q[0].z      <= z8_q;
    end
  end

  for (genvar k = 0; k < CB; k++) begin : g_div
    localparam int unsigned Sh = CB - 1 - k;
    logic [NW-1:0] shd;
    logic gex, gey;
    assign shd = dv_q[k] << Sh;
    assign gex = (rx_q[k] >= shd);
    assign gey = (ry_q[k] >= shd);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[k+1] <= gex ? rx_q[k] - shd : rx_q[k];
        ry_q[k+1] <= gey ? ry_q[k] - shd : ry_q[k];
        dv_q[k+1] <= dv_q[k];
        qx_q[k+1] <= qx_q[k] | (CB'(gex) << Sh);
        qy_q[k+1] <= qy_q[k] | (CB'(gey) << Sh);
        dc_q[k+1] <= dc_q[k];
      end
    end
  end

  // ---------------- result: saturation, behind, visibility ----------------
  localparam logic [CB-1:0] MaxV = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] MinV = {1'b1, {(CB-1){1'b0}}};

  logic [CB-1:0] satx, saty, resx, resy;
  logic [CmpW:0] colsp1, rowsp1;
  logic          res_on;

  always_comb begin
    if (dc_q[CB].ovx) begin
      satx = dc_q[CB].negx ? MinV : MaxV;
    end else if (dc_q[CB].negx) begin
      satx = (qx_q[CB] > MinV) ? MinV : CB'(-qx_q[CB]);
    end else begin
      satx = qx_q[CB][CB-1] ? MaxV : qx_q[CB];
    end
    if (dc_q[CB].ovy) begin
      saty = dc_q[CB].negy ? MinV : MaxV;
    end else if (dc_q[CB].negy) begin
      saty = (qy_q[CB] > MinV) ? MinV : CB'(-qy_q[CB]);
    end else begin
      saty = qy_q[CB][CB-1] ? MaxV : qy_q[CB];
    end
    colsp1 = (CmpW+1)'(cols_q) + (CmpW+1)'(1);
    rowsp1 = (CmpW+1)'(rows_q) + (CmpW+1)'(1);
    resx   = dc_q[CB].behind ? colsp1[CB-1:0] : satx;
    resy   = dc_q[CB].behind ? rowsp1[CB-1:0] : saty;
    res_on = !dc_q[CB].behind && !satx[CB-1] && !saty[CB-1]
             && (CmpW'(satx) < CmpW'(cols_q)) && (CmpW'(saty) < CmpW'(rows_q));
  end

  // ---------------- output register and skid slot ----------------
  logic [CB-1:0] out_x_q, out_y_q, out_z_q, sk_x_q, sk_y_q, sk_z_q;
  logic          out_behind_q, out_on_q, sk_behind_q, sk_on_q;
  logic          load_out;

  assign load_out = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (skid_v_q) begin
        out_x_q      <= sk_x_q;
        out_y_q      <= sk_y_q;
        out_z_q      <= sk_z_q;
        out_behind_q <= sk_behind_q;
        out_on_q     <= sk_on_q;
      end else begin
        out_x_q      <= resx;
        out_y_q      <= resy;
        out_z_q      <= dc_q[CB].z;
        out_behind_q <= dc_q[CB].behind;
        out_on_q     <= res_on;
      end
    end else if (push) begin
      sk_x_q      <= resx;
      sk_y_q      <= resy;
      sk_z_q      <= dc_q[CB].z;
      sk_behind_q <= dc_q[CB].behind;
      sk_on_q     <= res_on;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = IOW'({out_z_q, out_y_q, out_x_q});
  always_comb begin
    m_axis_tuser                        = '0;
    m_axis_tuser[cpp_pkg::FlagBehind]   = out_behind_q;
    m_axis_tuser[cpp_pkg::FlagOnScreen] = out_on_q;
  end

  // ---------------- assertions ----------------
  `CPP_ASSERT_IMP(a_skid_needs_out, skid_v_q, out_v_q, "skid slot full with output empty")
  `CPP_ASSERT_NXT(a_skid_catches, out_v_q && !m_axis_tready && push, skid_v_q,
                  "item pushed into stalled output was not kept")
  `CPP_ASSERT_IMP(a_behind_off, out_v_q && out_behind_q, !out_on_q,
                  "point behind camera reported on screen")
  `CPP_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, v_q[1],
                  "accepted item missing from first stage")

endmodule

`default_nettype wire
